// File: rtl/bce_pkg.sv
// shared types, constants and the binomial coefficient table of the bezier evaluator
`default_nettype none

package bce_pkg;

  // configuration register
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] CFG_DEGREE_RESET = 4'd3;

  // highest degree the index fields can carry
  localparam int MAX_DEG = 15;
  localparam int IDX_W = 4;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // binomial coefficients up to degree 15 fit in 13 bits
  localparam int BINOM_W = 13;
  localparam int BINOM_N = (MAX_DEG + 1) * (MAX_DEG + 1);

  typedef logic [0:BINOM_N-1][BINOM_W-1:0] binom_table_t;

  // request and result payloads
  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        param_t;
  } bce_req_t;

  typedef struct packed {
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic               overflow;
  } bce_res_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_RD,
    ST_WGT,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } bce_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic             start;
    logic             pow_en;
    logic             rd_en;
    logic             wgt_en;
    logic             mul_en;
    logic             acc_en;
    logic             fin_en;
    logic [IDX_W-1:0] t_idx;
    logic [IDX_W-1:0] u_idx;
    logic [IDX_W-1:0] n;
  } bce_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } bce_status_t;

  // pascal triangle, row r and column k at r*(MAX_DEG+1)+k
  function automatic binom_table_t build_binom_table();
    binom_table_t tbl;
    tbl = '0;
    for (int r = 0; r <= MAX_DEG; r++) begin
      for (int k = 0; k <= r; k++) begin
        if (k == 0 || k == r) begin
          tbl[r*(MAX_DEG+1)+k] = BINOM_W'(1);
        end else begin
          tbl[r*(MAX_DEG+1)+k] = tbl[(r-1)*(MAX_DEG+1)+k-1] + tbl[(r-1)*(MAX_DEG+1)+k];
        end
      end
    end
    return tbl;
  endfunction

  localparam binom_table_t BINOM_TABLE = build_binom_table();

endpackage

`default_nettype wire

// File: rtl/bce_if.sv
// valid/ready channel interfaces for requests and results
`default_nettype none

interface bce_req_if;
  import bce_pkg::*;

  logic     valid;
  logic     ready;
  bce_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bce_res_if;
  import bce_pkg::*;

  logic     valid;
  logic     ready;
  bce_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/bce_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module bce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bce_ctrl.sv
// controller: degree register, request handshake and evaluation sequencing
`default_nettype none

module bce_ctrl #(
  parameter int MAX_POINTS = 16,
  parameter int AW         = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bce_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                         req_valid_i,
  input  wire logic                         req_op_i,
  input  wire logic [bce_pkg::IDX_W-1:0]    req_index_i,
  output logic                              req_ready_o,
  output logic                              ram_we_o,
  output logic [AW-1:0]                     ram_waddr_o,
  output logic                              ram_re_o,
  output logic [AW-1:0]                     ram_raddr_o,
  output bce_pkg::bce_cmd_t                 cmd_o,
  input  wire bce_pkg::bce_status_t         status_i
);
  import bce_pkg::*;

  localparam int NMAX = (MAX_POINTS - 1 < MAX_DEG) ? MAX_POINTS - 1 : MAX_DEG;
  localparam int EXT_W = 6;

  bce_state_e       state_q, state_d;
  logic [CFG_W-1:0] cfg_degree_q;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] n_eff;
  logic [EXT_W-1:0] widx_ext;
  logic [EXT_W-1:0] ridx_ext;

  // degree clamped to the table size
  assign n_eff = (cfg_degree_q > IDX_W'(NMAX)) ? IDX_W'(NMAX) : cfg_degree_q;

  // ram addresses from the 4-bit indexes
  assign widx_ext    = {{(EXT_W-IDX_W){1'b0}}, req_index_i};
  assign ridx_ext    = {{(EXT_W-IDX_W){1'b0}}, cnt_q};
  assign ram_waddr_o = widx_ext[AW-1:0];
  assign ram_raddr_o = ridx_ext[AW-1:0];

  // degree register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_degree_q <= CFG_DEGREE_RESET;
    end else if (cfg_we_i) begin
      cfg_degree_q <= cfg_wdata_i;
    end
  end

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    req_ready_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    cmd_o       = '0;
    cmd_o.n     = n_eff;
    cmd_o.t_idx = cnt_q;
    cmd_o.u_idx = n_eff - cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_op_i == OP_LOAD) begin
            ram_we_o = (widx_ext < EXT_W'(MAX_POINTS));
          end else begin
            cmd_o.start = 1'b1;
            if (n_eff == '0) begin
              cnt_d   = '0;
              state_d = ST_RD;
            end else begin
              cnt_d   = IDX_W'(1);
              state_d = ST_POW;
            end
          end
        end
      end
      ST_POW: begin
        cmd_o.pow_en = 1'b1;
        if (cnt_q == n_eff) begin
          cnt_d   = '0;
          state_d = ST_RD;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        ram_re_o    = 1'b1;
        state_d     = ST_WGT;
      end
      ST_WGT: begin
        cmd_o.wgt_en = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (cnt_q == n_eff) begin
          state_d = ST_FIN;
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.fin_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bce_dpath.sv
// datapath: powers of t and 1-t, bernstein weights, accumulation and result register
`default_nettype none

module bce_dpath #(
  parameter int T_FRAC_BITS = 15
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bce_pkg::bce_cmd_t    cmd_i,
  output bce_pkg::bce_status_t      status_o,
  input  wire logic [15:0]          param_t_i,
  input  wire logic [63:0]          ram_rdata_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output bce_pkg::bce_res_t         res_payload_o
);
  import bce_pkg::*;

  localparam int TW   = T_FRAC_BITS + 1;
  localparam int TUW  = 2 * TW;
  localparam int WW   = TUW + BINOM_W;
  localparam int PW   = 32 + TW + 1;
  localparam int ACCW = PW + 5;

  localparam logic [TW-1:0]          ONE      = TW'(1) << T_FRAC_BITS;
  localparam logic [TW-1:0]          HALF     = TW'(1) << (T_FRAC_BITS - 1);
  localparam logic [31:0]            ONE32    = 32'(1) << T_FRAC_BITS;
  localparam logic signed [ACCW-1:0] HALF_ACC = ACCW'(HALF);
  localparam logic signed [ACCW-1:0] SAT_MAX  = ACCW'($signed(32'h7fff_ffff));
  localparam logic signed [ACCW-1:0] SAT_MIN  = ACCW'($signed(32'h8000_0000));

  logic [TW-1:0]          t_q, u_q;
  logic [TW-1:0]          tcur_q, ucur_q;
  logic [TW-1:0]          tpow_q [MAX_DEG+1];
  logic [TW-1:0]          upow_q [MAX_DEG+1];
  logic [TUW-1:0]         tu_q;
  logic [BINOM_W-1:0]     c_q;
  logic [TW-1:0]          w_q;
  logic signed [PW-1:0]   prod_x_q, prod_y_q;
  logic signed [ACCW-1:0] acc_x_q, acc_y_q;
  logic                   res_valid_q;
  bce_res_t               res_q;

  logic [31:0]            t_in32;
  logic [TW-1:0]          t_start;
  logic [TUW-1:0]         tp_sum, up_sum;
  logic [TW-1:0]          tnext, unext;
  logic [WW-1:0]          wsum, wsh;
  logic [TW-1:0]          w_d;
  logic signed [PW-1:0]   px_ext, py_ext, w_ext;
  logic [31:0]            fx, fy;
  logic                   ovx, ovy;

  // round half up, floor by shift, then saturate to signed 32 bits
  function automatic logic [32:0] finish(input logic signed [ACCW-1:0] acc);
    logic signed [ACCW-1:0] q;
    logic signed [ACCW-1:0] r;
    logic [32:0]            res;
    q = acc + HALF_ACC;
    r = q >>> T_FRAC_BITS;
    if (r > SAT_MAX) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (r < SAT_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, r[31:0]};
    end
    return res;
  endfunction

  // t clamped to one
  assign t_in32  = {16'b0, param_t_i};
  assign t_start = (t_in32 > ONE32) ? ONE : t_in32[TW-1:0];

  // next powers, rounded half up
  assign tp_sum = ({{TW{1'b0}}, tcur_q} * {{TW{1'b0}}, t_q}) + TUW'(HALF);
  assign up_sum = ({{TW{1'b0}}, ucur_q} * {{TW{1'b0}}, u_q}) + TUW'(HALF);
  assign tnext  = tp_sum[T_FRAC_BITS +: TW];
  assign unext  = up_sum[T_FRAC_BITS +: TW];

  // weight from the power product and coefficient, clamped to one
  assign wsum = ({{BINOM_W{1'b0}}, tu_q} * {{TUW{1'b0}}, c_q}) + WW'(HALF);
  assign wsh  = wsum >> T_FRAC_BITS;
  assign w_d  = (wsh > WW'(ONE)) ? ONE : wsh[TW-1:0];

  // operands of the point products
  assign px_ext = PW'($signed(ram_rdata_i[63:32]));
  assign py_ext = PW'($signed(ram_rdata_i[31:0]));
  assign w_ext  = $signed({{(PW-TW){1'b0}}, w_q});

  assign {ovx, fx} = finish(acc_x_q);
  assign {ovy, fy} = finish(acc_y_q);

  // power tables and running powers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      t_q       <= t_start;
      u_q       <= ONE - t_start;
      tcur_q    <= ONE;
      ucur_q    <= ONE;
      tpow_q[0] <= ONE;
      upow_q[0] <= ONE;
    end else if (cmd_i.pow_en) begin
      tcur_q              <= tnext;
      ucur_q              <= unext;
      tpow_q[cmd_i.t_idx] <= tnext;
      upow_q[cmd_i.t_idx] <= unext;
    end
  end

  // weight pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      tu_q <= {{TW{1'b0}}, tpow_q[cmd_i.t_idx]} * {{TW{1'b0}}, upow_q[cmd_i.u_idx]};
      c_q  <= BINOM_TABLE[{cmd_i.n, cmd_i.t_idx}];
    end
    if (cmd_i.wgt_en) begin
      w_q <= w_d;
    end
    if (cmd_i.mul_en) begin
      prod_x_q <= px_ext * w_ext;
      prod_y_q <= py_ext * w_ext;
    end
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_x_q <= acc_x_q + ACCW'(prod_x_q);
      acc_y_q <= acc_y_q + ACCW'(prod_y_q);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_en) begin
      res_q.curve_x  <= fx;
      res_q.curve_y  <= fy;
      res_q.overflow <= ovx | ovy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = res_valid_q & ~res_ready_i;
  assign res_valid_o       = res_valid_q;
  assign res_payload_o     = res_q;

endmodule

`default_nettype wire

// File: rtl/bezier_curve_evaluator_unit.sv
// top level of the bernstein-form bezier curve evaluator
//
//  channel  dir  handshake     carries
//  req_i    in   valid/ready   op, point_index, point_x, point_y, param_t
//  res_o    out  valid/ready   curve_x, curve_y, overflow
//  cfg      in   cfg_we_i      curve_degree (4 bits)
//
// a load request writes the point table directly.
// an evaluate request, n the effective degree, runs the power steps for the
// powers 1 to n, then the read, weight, product and accumulate steps for each
// control point through the one shared weight and product chain.
// reset sets the degree to 3; the point table holds nothing until loaded.
// the result register lets a new request in while a result waits; a finished
// evaluation holds in its last step until the result register is free.
`default_nettype none

module bezier_curve_evaluator_unit #(
  parameter int MAX_POINTS  = 16,
  parameter int T_FRAC_BITS = 15
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bce_pkg::CFG_W-1:0] cfg_wdata_i,
  bce_req_if.sink                        req_i,
  bce_res_if.source                      res_o
);
  import bce_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  bce_cmd_t    cmd;
  bce_status_t status;
  logic        ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_rdata;

  // sequencing
  bce_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.payload.op),
    .req_index_i (req_i.payload.point_index),
    .req_ready_o (req_i.ready),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // control point table, x in the upper half
  bce_ram #(
    .WIDTH (64),
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({req_i.payload.point_x, req_i.payload.point_y}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // arithmetic
  bce_dpath #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .param_t_i     (req_i.payload.param_t),
    .ram_rdata_i   (ram_rdata),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .res_payload_o (res_o.payload)
  );

endmodule

`default_nettype wire

// File: bench/bezier_curve_evaluator_unit_test.sv
// self-checking bench for the bezier curve evaluator: point loads, curve evaluations, degree setting
module bezier_curve_evaluator_unit_test;
  import bce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 16;
  localparam int T_FRAC_BITS = 15;
  localparam longint ONE_T = longint'(1) << T_FRAC_BITS;
  localparam longint HALF_T = longint'(1) << (T_FRAC_BITS - 1);
  localparam logic [15:0] T_ONE = 16'(ONE_T);
  localparam longint COORD_MAX = 2147483647;
  localparam longint COORD_MIN = -longint'(2147483647) - 1;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  // a load leaves no result behind, give it time to land before a degree write
  localparam int LOAD_SETTLE = 16;
  // longest evaluation is at degree 15
  localparam int EVAL_SETTLE = 100;
  localparam int CHUNKS = 10;
  localparam int CHUNK_ITEMS = 51;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bce_req_if req_ch ();
  bce_res_if res_ch ();

  bezier_curve_evaluator_unit #(
    .MAX_POINTS (MAX_POINTS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_ch),
    .res_o      (res_ch)
  );

  // shadow copy of the block state
  logic signed [31:0] point_x_mem [MAX_POINTS];
  logic signed [31:0] point_y_mem [MAX_POINTS];
  logic [CFG_W-1:0] degree_reg;

  bce_res_t expected_points [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round half up from Q.15 to a Q32.0 integer and clamp to signed 32 bits
  function automatic logic signed [31:0] round_coord(input longint acc, inout logic sat);
    longint q;
    q = (acc + HALF_T) >>> T_FRAC_BITS;
    if (q > COORD_MAX) begin
      sat = 1'b1;
      q = COORD_MAX;
    end
    if (q < COORD_MIN) begin
      sat = 1'b1;
      q = COORD_MIN;
    end
    return 32'(q);
  endfunction

  // curve point at t from the shadow table and degree
  function automatic bce_res_t bernstein_point(input logic [15:0] t_raw);
    longint t, u, c, w, acc_x, acc_y;
    longint tpow [0:MAX_DEG];
    longint upow [0:MAX_DEG];
    int n;
    logic sat;
    bce_res_t r;
    n = int'(degree_reg);
    if (n > MAX_POINTS - 1) n = MAX_POINTS - 1;
    t = (longint'(t_raw) > ONE_T) ? ONE_T : longint'(t_raw);
    u = ONE_T - t;
    tpow[0] = ONE_T;
    upow[0] = ONE_T;
    for (int i = 1; i <= n; i++) begin
      tpow[i] = (tpow[i-1] * t + HALF_T) >> T_FRAC_BITS;
      upow[i] = (upow[i-1] * u + HALF_T) >> T_FRAC_BITS;
    end
    // binomial coefficient by exact running recurrence
    c = 1;
    acc_x = 0;
    acc_y = 0;
    for (int i = 0; i <= n; i++) begin
      w = (c * tpow[i] * upow[n-i] + HALF_T) >> T_FRAC_BITS;
      if (w > ONE_T) w = ONE_T;
      acc_x += longint'(point_x_mem[i]) * w;
      acc_y += longint'(point_y_mem[i]) * w;
      c = c * longint'(n - i) / longint'(i + 1);
    end
    sat = 1'b0;
    r.curve_x = round_coord(acc_x, sat);
    r.curve_y = round_coord(acc_y, sat);
    r.overflow = sat;
    return r;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_request(input bce_req_t req);
    logic accepted;
    accepted = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= req;
    while (!accepted) begin
      @(negedge clk_i);
      accepted = (req_ch.ready === 1'b1);
      @(posedge clk_i);
    end
    // update shadow state or queue the expected point
    if (req.op == OP_LOAD) begin
      if (int'(req.point_index) < MAX_POINTS) begin
        point_x_mem[req.point_index] = req.point_x;
        point_y_mem[req.point_index] = req.point_y;
      end
    end else begin
      expected_points.insert(expected_points.size(), bernstein_point(req.param_t));
    end
  endtask

  task automatic load_point(input logic [IDX_W-1:0] idx, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    bce_req_t req;
    req = '0;
    req.op = OP_LOAD;
    req.point_index = idx;
    req.point_x = x;
    req.point_y = y;
    req.param_t = 16'($urandom());
    send_request(req);
  endtask

  task automatic evaluate_at(input logic [15:0] t);
    bce_req_t req;
    req.op = OP_EVAL;
    req.point_index = IDX_W'($urandom());
    req.point_x = 32'($urandom());
    req.point_y = 32'($urandom());
    req.param_t = t;
    send_request(req);
  endtask

  // stop requesting and let every pending result drain
  task automatic wait_until_idle(input int settle_cycles);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [CFG_W-1:0] deg);
    wait_until_idle(LOAD_SETTLE);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= deg;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    degree_reg = deg;
  endtask

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'($urandom_range(511)) - 32'd256;
      default: return 32'($urandom());
    endcase
  endfunction

  // result side: random backpressure
  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result side: compare each accepted result with the oldest expectation
  always @(negedge clk_i) begin
    bce_res_t want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_points.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result x=%0d y=%0d ovf=%0b", res_ch.payload.curve_x,
                   res_ch.payload.curve_y, res_ch.payload.overflow);
      end else begin
        want = expected_points.pop_front();
        if (res_ch.payload.curve_x !== want.curve_x ||
            res_ch.payload.curve_y !== want.curve_y ||
            res_ch.payload.overflow !== want.overflow) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                     want.curve_x, want.curve_y, want.overflow, res_ch.payload.curve_x,
                     res_ch.payload.curve_y, res_ch.payload.overflow);
        end
      end
    end
  end

  // reset degree, field extremes and t at and above one
  task automatic test_reset_degree();
    load_point(4'd0, Q_MAX, Q_MIN);
    load_point(4'd1, Q_MIN, Q_MAX);
    load_point(4'd2, 32'sd0, -32'sd1);
    load_point(4'd3, 32'sh0001_8000, 32'sh5A5A_A5A5);
    evaluate_at(16'd0);
    evaluate_at(T_ONE);
    evaluate_at(16'hFFFF);
    evaluate_at(T_ONE >> 1);
  endtask

  // weights that round to more than one saturate both coordinates
  task automatic test_saturation();
    write_degree(CFG_W'(2));
    for (int i = 0; i < 3; i++) load_point(IDX_W'(i), Q_MAX, Q_MIN);
    evaluate_at(16'd150);
    evaluate_at(T_ONE >> 1);
  endtask

  // degree zero returns control point 0
  task automatic test_degree_zero();
    write_degree(CFG_W'(0));
    evaluate_at(16'd12345);
  endtask

  // highest degree walks the whole table
  task automatic test_full_degree();
    write_degree(CFG_W'(MAX_DEG));
    for (int i = 4; i < MAX_POINTS; i++)
      load_point(IDX_W'(i), 32'(i * 196608), -32'(i * 262144));
    evaluate_at(16'd1);
    evaluate_at(T_ONE - 16'd1);
  endtask

  // random loads and evaluations over a sweep of degrees
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    logic [CFG_W-1:0] deg;
    logic [15:0] t;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      case (chunk)
        0: deg = CFG_W'(1);
        1: deg = CFG_W'(MAX_DEG);
        default: deg = CFG_W'($urandom_range(MAX_DEG));
      endcase
      write_degree(deg);
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        // now and then hold off until the result queue runs dry
        if ($urandom_range(63) == 0) wait_until_idle(0);
        if ($urandom_range(99) < 35) begin
          load_point(IDX_W'($urandom_range(MAX_POINTS - 1)), random_coord(), random_coord());
        end else begin
          case ($urandom_range(9))
            0: t = 16'd0;
            1: t = T_ONE;
            2: t = 16'($urandom_range(65535, int'(T_ONE) + 1));
            default: t = 16'($urandom_range(int'(T_ONE)));
          endcase
          evaluate_at(t);
        end
      end
    end
  endtask

  // test sequence
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    res_ch.ready = 1'b0;
    degree_reg = CFG_DEGREE_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_degree();
    test_saturation();
    test_degree_zero();
    test_full_degree();
    test_random_traffic(18, 63);
    test_random_traffic(63, 18);
    test_random_traffic(0, 0);

    wait_until_idle(EVAL_SETTLE);
    if (expected_points.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_points.size());
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sim.f
rtl/bce_pkg.sv
rtl/bce_if.sv
rtl/bce_ram.sv
rtl/bce_ctrl.sv
rtl/bce_dpath.sv
rtl/bezier_curve_evaluator_unit.sv
bench/bezier_curve_evaluator_unit_test.sv
